FILE: design/hsl_range_pixel_select_core_defines.svh
// assertion macros for the hsl range pixel select checker
`ifndef HSL_RANGE_PIXEL_SELECT_CORE_DEFINES_SVH
`define HSL_RANGE_PIXEL_SELECT_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define HRPS_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hsl select check failed");

// next-cycle implication, off during reset
`define HRPS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hsl select check failed");

// next-cycle implication, checked through reset too
`define HRPS_ASSERT_NEXT_ALWAYS(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("hsl select check failed");

`endif

FILE: design/hsl_rps_pkg.sv
// shared types and constants for the hsl range pixel select core
`default_nettype none
package hsl_rps_pkg;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef enum logic [2:0] {
    REG_HUE_TARGET   = 3'd0,
    REG_HUE_BAND     = 3'd1,
    REG_SAT_TARGET   = 3'd2,
    REG_SAT_BAND     = 3'd3,
    REG_LIGHT_TARGET = 3'd4,
    REG_LIGHT_BAND   = 3'd5
  } reg_index_t;

  localparam int ADDR_W   = 5;
  localparam int HUE_W    = 9;
  localparam int CH_W     = 8;
  localparam int Y_W      = 11;
  localparam int NUM_W    = 25;
  localparam int DH_W     = 16;
  localparam int DS_W     = 17;
  localparam int QH_W     = 9;
  localparam int QS_W     = 8;
  localparam int DIV_ST   = QH_W;

  localparam logic [13:0] HUE_SCALE = 14'd12000;
  localparam logic [7:0]  HUE_DSCALE = 8'd200;
  localparam logic [16:0] SAT_SCALE = 17'd131070;
  localparam logic signed [11:0] HUE_FULL = 12'sd360;

endpackage
`default_nettype wire

FILE: design/hsl_range_pixel_select_core.sv
// top level: pipelined rgb to hsl conversion, window test and pixel select
//
//  channel  | signals                              | dir
//  ---------+--------------------------------------+-----
//  pixel in | pix_valid pix_stall orig_pixel alt_pixel | in
//  result   | res_valid res_stall out_pixel matched     | out
//  config   | psel penable pwrite paddr pwdata prdata pready | apb
//
//  one request per cycle through 13 register stages, unless a stalled result backs up a full pipe
//  the nine-step hue divider, one bit a stage, sets the depth, sat divider runs beside it
//  rst is synchronous and clears every stage valid and the registers
//  each stage holds while the stage after it is full and stalled
//  bubbles collapse, so requests are taken while a result waits
`default_nettype none
module hsl_range_pixel_select_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_valid,
  output logic             pix_stall,
  input  wire logic [31:0] orig_pixel,
  input  wire logic [31:0] alt_pixel,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [31:0]      out_pixel,
  output logic             matched,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [hsl_rps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NDS = hsl_rps_pkg::DIV_ST;

  // configuration
  logic [hsl_rps_pkg::HUE_W-1:0] hue_target, hue_band;
  logic [7:0] sat_target, sat_band, light_target, light_band;
  hsl_rps_pkg::reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = hsl_rps_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_target   <= '0;
      hue_band     <= '0;
      sat_target   <= '0;
      sat_band     <= '0;
      light_target <= '0;
      light_band   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_idx)
        hsl_rps_pkg::REG_HUE_TARGET:   hue_target   <= pwdata[8:0];
        hsl_rps_pkg::REG_HUE_BAND:     hue_band     <= pwdata[8:0];
        hsl_rps_pkg::REG_SAT_TARGET:   sat_target   <= pwdata[7:0];
        hsl_rps_pkg::REG_SAT_BAND:     sat_band     <= pwdata[7:0];
        hsl_rps_pkg::REG_LIGHT_TARGET: light_target <= pwdata[7:0];
        hsl_rps_pkg::REG_LIGHT_BAND:   light_band   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hsl_rps_pkg::REG_HUE_TARGET:   prdata = {23'd0, hue_target};
      hsl_rps_pkg::REG_HUE_BAND:     prdata = {23'd0, hue_band};
      hsl_rps_pkg::REG_SAT_TARGET:   prdata = {24'd0, sat_target};
      hsl_rps_pkg::REG_SAT_BAND:     prdata = {24'd0, sat_band};
      hsl_rps_pkg::REG_LIGHT_TARGET: prdata = {24'd0, light_target};
      hsl_rps_pkg::REG_LIGHT_BAND:   prdata = {24'd0, light_band};
      default:                       prdata = '0;
    endcase
  end

  // flow control
  logic           v1, v2;
  logic [NDS:0]   dv;
  logic           rdy_out, rdy1, rdy2;
  logic [NDS:0]   rdy_d;

  assign rdy_out = !res_valid || !res_stall;
  assign rdy_d[NDS] = !dv[NDS] || rdy_out;
  for (genvar j = 0; j < NDS; j++) begin : g_rdy
    assign rdy_d[j] = !dv[j] || rdy_d[j+1];
  end
  assign rdy2 = !v2 || rdy_d[0];
  assign rdy1 = !v1 || rdy2;
  assign pix_stall = !rdy1;

  // stage 1: max, min, sector
  logic [7:0] in_r, in_g, in_b, mx_c, mn_c;
  hsl_rps_pkg::sector_t sect_c;

  assign in_r = orig_pixel[23:16];
  assign in_g = orig_pixel[15:8];
  assign in_b = orig_pixel[7:0];

  always_comb begin
    mx_c = in_r;
    mn_c = in_r;
    if (in_g > mx_c) mx_c = in_g;
    if (in_b > mx_c) mx_c = in_b;
    if (in_g < mn_c) mn_c = in_g;
    if (in_b < mn_c) mn_c = in_b;
    priority if (in_r == mx_c) sect_c = hsl_rps_pkg::SECT_RED;
    else if (in_g == mx_c)     sect_c = hsl_rps_pkg::SECT_GREEN;
    else                       sect_c = hsl_rps_pkg::SECT_BLUE;
  end

  logic [31:0] orig1, alt1;
  logic [7:0]  mx1, mn1;
  hsl_rps_pkg::sector_t sect1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (rdy1) v1 <= pix_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      orig1 <= orig_pixel;
      alt1  <= alt_pixel;
      mx1   <= mx_c;
      mn1   <= mn_c;
      sect1 <= sect_c;
    end
  end

  // stage 2: difference, denominator, sector offset, lightness
  localparam int Y_W_LOC = hsl_rps_pkg::Y_W;
  logic [7:0]  r1, g1, b1, d_c, den_c;
  logic [8:0]  s_c;
  logic [Y_W_LOC-1:0] y_c;
  logic [16:0] lsum_c;

  assign r1 = orig1[23:16];
  assign g1 = orig1[15:8];
  assign b1 = orig1[7:0];
  assign d_c = mx1 - mn1;
  assign s_c = {1'b0, mx1} + {1'b0, mn1};
  assign den_c = (s_c < 9'd255) ? s_c[7:0] : 8'(9'd510 - s_c);
  assign lsum_c = {s_c, 8'd0} + {8'd0, s_c} + 17'd1;

  always_comb begin
    unique case (sect1)
      hsl_rps_pkg::SECT_RED:
        if (g1 >= b1) y_c = {3'd0, g1 - b1};
        else          y_c = 11'(11'd6 * {3'd0, d_c}) - {3'd0, b1 - g1};
      hsl_rps_pkg::SECT_GREEN:
        y_c = {2'd0, d_c, 1'b0} + {3'd0, b1} - {3'd0, r1};
      hsl_rps_pkg::SECT_BLUE:
        y_c = {1'd0, d_c, 2'b0} + {3'd0, r1} - {3'd0, g1};
      default:
        y_c = '0;
    endcase
  end

  logic [31:0] orig2, alt2;
  logic [7:0]  d2, den2, lit2;
  logic [Y_W_LOC-1:0] y2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      orig2 <= orig1;
      alt2  <= alt1;
      d2    <= d_c;
      den2  <= den_c;
      y2    <= y_c;
      lit2  <= lsum_c[16:9];
    end
  end

  // stage 3: dividends and divisors, then one quotient bit a stage
  logic [hsl_rps_pkg::NUM_W-1:0] rem_h [0:NDS];
  logic [hsl_rps_pkg::NUM_W-1:0] rem_s [0:NDS];
  logic [hsl_rps_pkg::DH_W-1:0]  div_h [0:NDS];
  logic [hsl_rps_pkg::DS_W-1:0]  div_s [0:NDS];
  logic [hsl_rps_pkg::QH_W-1:0]  q_h   [0:NDS];
  logic [hsl_rps_pkg::QS_W-1:0]  q_s   [0:NDS];
  logic [7:0]  lit_p  [0:NDS];
  logic        gray_p [0:NDS];
  logic [31:0] orig_p [0:NDS];
  logic [31:0] alt_p  [0:NDS];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (rdy_d[0]) dv[0] <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy_d[0]) begin
      rem_h[0]  <= 25'(hsl_rps_pkg::HUE_SCALE * y2) + {17'd0, d2};
      div_h[0]  <= 16'(hsl_rps_pkg::HUE_DSCALE * d2);
      rem_s[0]  <= 25'(hsl_rps_pkg::SAT_SCALE * d2) + {17'd0, den2};
      div_s[0]  <= {den2, 9'd0};
      q_h[0]    <= '0;
      q_s[0]    <= '0;
      lit_p[0]  <= lit2;
      gray_p[0] <= (d2 == 8'd0);
      orig_p[0] <= orig2;
      alt_p[0]  <= alt2;
    end
  end

  for (genvar j = 0; j < NDS; j++) begin : g_div
    localparam int K = NDS - 1 - j;
    logic [25:0] dh_sh;
    logic        ge_h;
    logic [hsl_rps_pkg::NUM_W-1:0] rem_h_next;
    logic [hsl_rps_pkg::NUM_W-1:0] rem_s_next;
    logic [hsl_rps_pkg::QS_W-1:0]  q_s_next;

    assign dh_sh = {10'd0, div_h[j]} << K;
    assign ge_h  = {1'b0, rem_h[j]} >= dh_sh;
    assign rem_h_next = ge_h ? rem_h[j] - dh_sh[24:0] : rem_h[j];

    if (K < hsl_rps_pkg::QS_W) begin : g_sat
      logic [25:0] ds_sh;
      logic        ge_s;
      assign ds_sh = {9'd0, div_s[j]} << K;
      assign ge_s  = {1'b0, rem_s[j]} >= ds_sh;
      assign rem_s_next = ge_s ? rem_s[j] - ds_sh[24:0] : rem_s[j];
      assign q_s_next   = {q_s[j][hsl_rps_pkg::QS_W-2:0], ge_s};
    end else begin : g_sat_idle
      assign rem_s_next = rem_s[j];
      assign q_s_next   = q_s[j];
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (rdy_d[j+1]) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (rdy_d[j+1]) begin
        rem_h[j+1]  <= rem_h_next;
        rem_s[j+1]  <= rem_s_next;
        div_h[j+1]  <= div_h[j];
        div_s[j+1]  <= div_s[j];
        q_h[j+1]    <= {q_h[j][hsl_rps_pkg::QH_W-2:0], ge_h};
        q_s[j+1]    <= q_s_next;
        lit_p[j+1]  <= lit_p[j];
        gray_p[j+1] <= gray_p[j];
        orig_p[j+1] <= orig_p[j];
        alt_p[j+1]  <= alt_p[j];
      end
    end
  end

  // window test into the output register
  logic [9:0]         hue_v;
  logic [7:0]         sat_v;
  logic signed [11:0] hue_s, hue_lo, hue_hi;
  logic signed [9:0]  sat_s, sat_lo, sat_hi, lit_s, lit_lo, lit_hi;
  logic               hue_ok, sat_ok, lit_ok;

  assign hue_v  = gray_p[NDS] ? 10'd0 : {1'b0, q_h[NDS]} + 10'd1;
  assign sat_v  = gray_p[NDS] ? 8'd0 : q_s[NDS];
  assign hue_s  = $signed({2'b0, hue_v});
  assign hue_lo = $signed({3'b0, hue_target}) - $signed({3'b0, hue_band});
  assign hue_hi = $signed({3'b0, hue_target}) + $signed({3'b0, hue_band});
  assign sat_s  = $signed({2'b0, sat_v});
  assign sat_lo = $signed({2'b0, sat_target}) - $signed({2'b0, sat_band});
  assign sat_hi = $signed({2'b0, sat_target}) + $signed({2'b0, sat_band});
  assign lit_s  = $signed({2'b0, lit_p[NDS]});
  assign lit_lo = $signed({2'b0, light_target}) - $signed({2'b0, light_band});
  assign lit_hi = $signed({2'b0, light_target}) + $signed({2'b0, light_band});

  assign hue_ok = (hue_s >= hue_lo && hue_s <= hue_hi)
               || (hue_lo < 12'sd0 && hue_s >= hue_lo + hsl_rps_pkg::HUE_FULL)
               || (hue_hi > hsl_rps_pkg::HUE_FULL
                   && hue_s < hue_hi - hsl_rps_pkg::HUE_FULL);
  assign sat_ok = sat_s >= sat_lo && sat_s <= sat_hi;
  assign lit_ok = lit_s >= lit_lo && lit_s <= lit_hi;

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (rdy_out) res_valid <= dv[NDS];
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      matched   <= hue_ok && sat_ok && lit_ok;
      out_pixel <= (hue_ok && sat_ok && lit_ok) ? alt_p[NDS] : orig_p[NDS];
    end
  end

endmodule
`default_nettype wire

FILE: design/hsl_rps_checker.sv
// port-level checker for the hsl range pixel select core, with its bind
`default_nettype none
`include "hsl_range_pixel_select_core_defines.svh"
module hsl_rps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pix_valid,
  input wire logic        pix_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [31:0] out_pixel,
  input wire logic        matched
);

  // no result straight out of reset
  `HRPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !res_valid)

  // a stalled result holds its payload
  `HRPS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(out_pixel) && $stable(matched))

  // nothing stalls the input while the output drains
  `HRPS_ASSERT_IMPL(a_flow_through, clk, rst, !res_stall, !pix_stall)

  // a held result with a pixel waiting means a full pipe, so the result stays valid
  `HRPS_ASSERT_NEXT(a_pix_pending, clk, rst, pix_valid && pix_stall && res_stall && res_valid, res_valid)

endmodule

bind hsl_range_pixel_select_core hsl_rps_checker u_hsl_rps_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_pixel (out_pixel),
  .matched   (matched)
);
`default_nettype wire
